/* sv/lrk4_pkg.sv */
`default_nettype none

package lrk4_pkg;

    localparam int LRK4_VALUE_BITS = 32;
    localparam int LRK4_FRAC_BITS  = 22;

    // magnitude width of a multiplier operand: state, coefficients, h and the divide-by-6 words
    function automatic int lrk4_mag_width(input int vb);
        return (vb + 3 > 32) ? vb + 3 : 32;
    endfunction

    // multiplier product scaling
    localparam logic [1:0] SH_FRAC = 2'd0;
    localparam logic [1:0] SH_H    = 2'd1;
    localparam logic [1:0] SH_DIV  = 2'd2;

    // sequencer operations
    localparam logic [3:0] OP_DX  = 4'd0;
    localparam logic [3:0] OP_DY  = 4'd1;
    localparam logic [3:0] OP_XY  = 4'd2;
    localparam logic [3:0] OP_BZ  = 4'd3;
    localparam logic [3:0] OP_KX  = 4'd4;
    localparam logic [3:0] OP_KY  = 4'd5;
    localparam logic [3:0] OP_KZ  = 4'd6;
    localparam logic [3:0] OP_D6X = 4'd7;
    localparam logic [3:0] OP_D6Y = 4'd8;
    localparam logic [3:0] OP_D6Z = 4'd9;

    // register indexes
    localparam logic [2:0] REG_METHOD  = 3'd0;
    localparam logic [2:0] REG_SIGMA   = 3'd1;
    localparam logic [2:0] REG_RHO     = 3'd2;
    localparam logic [2:0] REG_BETA    = 3'd3;
    localparam logic [2:0] REG_STEP    = 3'd4;
    localparam logic [2:0] REG_START_X = 3'd5;
    localparam logic [2:0] REG_START_Y = 3'd6;
    localparam logic [2:0] REG_START_Z = 3'd7;

    localparam logic        METHOD_RST = 1'b1;
    localparam logic [30:0] SIGMA_RST  = 31'd41943040;
    localparam logic [30:0] RHO_RST    = 31'd419262628;
    localparam logic [30:0] BETA_RST   = 31'd11184811;
    localparam logic [31:0] STEP_RST   = 32'd4294967;
    localparam logic [31:0] START_RST  = 32'd4194304;

    typedef struct packed {
        logic       go;
        logic [1:0] sel;
    } lrk4_mcmd_t;

    typedef struct packed {
        logic done;
        logic sat;
    } lrk4_mstat_t;

endpackage

`default_nettype wire

/* sv/lorenz_rk4_integrator_unit.sv */
// Lorenz attractor integrator, one step per input word.
// s_valid/s_ready carries one tick word with s_restart; restart reloads the start
// point and clears the step count before the tick. Each tick yields one result word
// on m_valid/m_ready: the point and step index before the step, plus an overflow
// flag for any saturation inside the step. The point then advances by one step of
// forward Euler (method 0) or classical RK4 (method 1).
// cfg_valid/cfg_ready writes the registers by index; cfg_ready is always high.
// Write them only while the block is idle.
// Timing: every product goes through one shared multiplier that takes one 16-bit
// digit per cycle. An RK4 tick takes 28 products plus 3 for the divide by six.
// s_ready is high only while the sequencer idles.
// The finished word sits in the output register; the next tick is taken while it
// waits, and if it still waits when that tick finishes, the sequencer holds.
// Reset: registers return to defaults, the point to the start point, count to zero.
`default_nettype none

module lorenz_rk4_integrator_unit
    import lrk4_pkg::*;
#(
    parameter int VALUE_BITS = LRK4_VALUE_BITS,
    parameter int FRAC_BITS  = LRK4_FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_step_index,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic              m_overflow,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int VB     = VALUE_BITS;
    localparam int MW     = lrk4_mag_width(VALUE_BITS);
    localparam int OW     = MW + 1;
    localparam int WW     = MW + 3;
    localparam int DIV_SH = VALUE_BITS + 5;

    // reciprocal of six, exact for every rk4 sum magnitude
    localparam logic [63:0] RCP64 = ((64'd1 << DIV_SH) + 64'd5) / 64'd6;

    localparam logic signed [WW-1:0] VMAX_W = WW'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
    localparam logic signed [WW-1:0] VMIN_W = ~VMAX_W;
    localparam logic signed [WW-1:0] OMAX_W = WW'(64'h7FFF_FFFF);
    localparam logic signed [WW-1:0] OMIN_W = ~OMAX_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_STAGE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    function automatic logic signed [WW-1:0] wx(input logic signed [VB-1:0] v);
        return {{(WW - VB){v[VB-1]}}, v};
    endfunction

    function automatic logic signed [WW-1:0] s32w(input logic [31:0] v);
        return {{(WW - 32){v[31]}}, v};
    endfunction

    function automatic logic signed [OW-1:0] owx(input logic signed [VB-1:0] v);
        return {{(OW - VB){v[VB-1]}}, v};
    endfunction

    function automatic logic ovfv(input logic signed [WW-1:0] v);
        return (v > VMAX_W) || (v < VMIN_W);
    endfunction

    function automatic logic signed [VB-1:0] satv(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] c;
        c = (v > VMAX_W) ? VMAX_W : ((v < VMIN_W) ? VMIN_W : v);
        return c[VB-1:0];
    endfunction

    function automatic logic [31:0] out32(input logic signed [VB-1:0] p);
        logic signed [WW-1:0] v;
        v = wx(p);
        return (v > OMAX_W) ? 32'h7FFF_FFFF : ((v < OMIN_W) ? 32'h8000_0000 : v[31:0]);
    endfunction

    // configuration
    logic        method_reg, method_next;
    logic [30:0] sigma_reg, sigma_next;
    logic [30:0] rho_reg, rho_next;
    logic [30:0] beta_reg, beta_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] start_reg [3];
    logic [31:0] start_next [3];

    // sequencer
    logic [2:0]  state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic [1:0]  stage_reg, stage_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] cnt_reg, cnt_next;

    // point, slope operands, slopes and rk4 sum
    logic signed [VB-1:0] pos_reg [3];
    logic signed [VB-1:0] pos_next [3];
    logic signed [VB-1:0] s_reg [3];
    logic signed [VB-1:0] s_next [3];
    logic signed [VB-1:0] d_reg [3];
    logic signed [VB-1:0] d_next [3];
    logic signed [VB-1:0] k_reg [3];
    logic signed [VB-1:0] k_next [3];
    logic signed [WW-1:0] acc_reg [3];
    logic signed [WW-1:0] acc_next [3];

    // output word
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_idx_reg, m_idx_next;
    logic [31:0] m_x_reg, m_x_next;
    logic [31:0] m_y_reg, m_y_next;
    logic [31:0] m_z_reg, m_z_next;
    logic        m_ovf_reg, m_ovf_next;

    // shared multiplier
    lrk4_mcmd_t           mcmd;
    lrk4_mstat_t          mstat;
    logic signed [OW-1:0] ma, mb;
    logic signed [VB-1:0] m_res;
    logic                 iss_ovf;

    logic signed [WW-1:0] diff_yx, diff_rz, wb_dy, wb_bz;
    logic [1:0]           d6_sel;
    logic signed [WW-1:0] d6_mag, d6_q, d6_sum;
    logic signed [WW-1:0] stg_sum [3];
    logic signed [WW-1:0] stg_acc [3];

    lrk4_mul #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mcmd),
        .op_a    (ma),
        .op_b    (mb),
        .stat    (mstat),
        .res     (m_res)
    );

    assign diff_yx = wx(s_reg[1]) - wx(s_reg[0]);
    assign diff_rz = $signed({{(WW - 31){1'b0}}, rho_reg}) - wx(s_reg[2]);
    assign wb_dy   = wx(m_res) - wx(s_reg[1]);
    assign wb_bz   = wx(d_reg[2]) - wx(m_res);

    // divide by six: multiply magnitude plus three by the reciprocal, restore sign
    assign d6_sel = 2'(op_reg - OP_D6X);
    assign d6_mag = (acc_reg[d6_sel][WW-1] ? -acc_reg[d6_sel] : acc_reg[d6_sel]) + WW'(3);
    assign d6_q   = acc_reg[d6_sel][WW-1] ? -wx(m_res) : wx(m_res);
    assign d6_sum = wx(pos_reg[d6_sel]) + d6_q;

    // end of a slope evaluation: next stage point and running weighted sum
    always_comb begin
        logic signed [WW-1:0] kw, mag, hh, half;
        for (int i = 0; i < 3; i++) begin
            kw   = wx(k_reg[i]);
            mag  = kw[WW-1] ? -kw : kw;
            hh   = (mag + WW'(1)) >>> 1;
            half = kw[WW-1] ? -hh : hh;
            stg_sum[i] = wx(pos_reg[i]) + ((!method_reg || stage_reg == 2'd2) ? kw : half);
            if (stage_reg == 2'd0) begin
                stg_acc[i] = kw;
            end else if (stage_reg == 2'd3) begin
                stg_acc[i] = acc_reg[i] + kw;
            end else begin
                stg_acc[i] = acc_reg[i] + (kw <<< 1);
            end
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mcmd.go  = (state_reg == ST_ISSUE);
        mcmd.sel = SH_FRAC;
        ma       = '0;
        mb       = '0;
        iss_ovf  = 1'b0;
        unique case (op_reg)
            OP_DX: begin
                ma      = $signed({{(OW - 31){1'b0}}, sigma_reg});
                mb      = owx(satv(diff_yx));
                iss_ovf = ovfv(diff_yx);
            end
            OP_DY: begin
                ma      = owx(s_reg[0]);
                mb      = owx(satv(diff_rz));
                iss_ovf = ovfv(diff_rz);
            end
            OP_XY: begin
                ma = owx(s_reg[0]);
                mb = owx(s_reg[1]);
            end
            OP_BZ: begin
                ma = $signed({{(OW - 31){1'b0}}, beta_reg});
                mb = owx(s_reg[2]);
            end
            OP_KX: begin
                ma       = $signed({{(OW - 32){1'b0}}, h_reg});
                mb       = owx(d_reg[0]);
                mcmd.sel = SH_H;
            end
            OP_KY: begin
                ma       = $signed({{(OW - 32){1'b0}}, h_reg});
                mb       = owx(d_reg[1]);
                mcmd.sel = SH_H;
            end
            OP_KZ: begin
                ma       = $signed({{(OW - 32){1'b0}}, h_reg});
                mb       = owx(d_reg[2]);
                mcmd.sel = SH_H;
            end
            OP_D6X, OP_D6Y, OP_D6Z: begin
                ma       = OW'(d6_mag);
                mb       = OW'(RCP64);
                mcmd.sel = SH_DIV;
            end
            default: begin
                ma = '0;
            end
        endcase
    end

    // sequencer, configuration and output word
    always_comb begin
        method_next  = method_reg;
        sigma_next   = sigma_reg;
        rho_next     = rho_reg;
        beta_next    = beta_reg;
        h_next       = h_reg;
        start_next   = start_reg;
        state_next   = state_reg;
        op_next      = op_reg;
        stage_next   = stage_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        s_next       = s_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_z_next     = m_z_reg;
        m_ovf_next   = m_ovf_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_METHOD:  method_next   = cfg_data[0];
                REG_SIGMA:   sigma_next    = cfg_data[30:0];
                REG_RHO:     rho_next      = cfg_data[30:0];
                REG_BETA:    beta_next     = cfg_data[30:0];
                REG_STEP:    h_next        = cfg_data;
                REG_START_X: start_next[0] = cfg_data;
                REG_START_Y: start_next[1] = cfg_data;
                REG_START_Z: start_next[2] = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    for (int i = 0; i < 3; i++) begin
                        if (s_restart) begin
                            pos_next[i] = satv(s32w(start_reg[i]));
                            s_next[i]   = satv(s32w(start_reg[i]));
                        end else begin
                            s_next[i] = pos_reg[i];
                        end
                    end
                    if (s_restart) begin
                        cnt_next = '0;
                    end
                    ovf_next   = 1'b0;
                    stage_next = 2'd0;
                    op_next    = OP_DX;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                ovf_next   = ovf_reg | iss_ovf;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mstat.done) begin
                    ovf_next = ovf_reg | mstat.sat;
                    unique case (op_reg)
                        OP_DX: d_next[0] = m_res;
                        OP_DY: begin
                            d_next[1] = satv(wb_dy);
                            ovf_next  = ovf_next | ovfv(wb_dy);
                        end
                        OP_XY: d_next[2] = m_res;
                        OP_BZ: begin
                            d_next[2] = satv(wb_bz);
                            ovf_next  = ovf_next | ovfv(wb_bz);
                        end
                        OP_KX: k_next[0] = m_res;
                        OP_KY: k_next[1] = m_res;
                        OP_KZ: k_next[2] = m_res;
                        OP_D6X, OP_D6Y, OP_D6Z: begin
                            s_next[d6_sel] = satv(d6_sum);
                            ovf_next       = ovf_next | ovfv(d6_sum);
                        end
                        default: ovf_next = ovf_next;
                    endcase
                    if (op_reg == OP_KZ) begin
                        state_next = ST_STAGE;
                    end else if (op_reg == OP_D6Z) begin
                        state_next = ST_DONE;
                    end else begin
                        op_next    = op_reg + 4'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_STAGE: begin
                for (int i = 0; i < 3; i++) begin
                    acc_next[i] = stg_acc[i];
                    if (!method_reg || stage_reg != 2'd3) begin
                        s_next[i] = satv(stg_sum[i]);
                        ovf_next  = ovf_next | ovfv(stg_sum[i]);
                    end
                end
                if (!method_reg) begin
                    state_next = ST_DONE;
                end else if (stage_reg == 2'd3) begin
                    op_next    = OP_D6X;
                    state_next = ST_ISSUE;
                end else begin
                    stage_next = stage_reg + 2'd1;
                    op_next    = OP_DX;
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                // hand the pre-step point out, then commit the new one
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = cnt_reg;
                    m_x_next     = out32(pos_reg[0]);
                    m_y_next     = out32(pos_reg[1]);
                    m_z_next     = out32(pos_reg[2]);
                    m_ovf_next   = ovf_reg;
                    pos_next     = s_reg;
                    cnt_next     = cnt_reg + 32'd1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg  <= METHOD_RST;
            sigma_reg   <= SIGMA_RST;
            rho_reg     <= RHO_RST;
            beta_reg    <= BETA_RST;
            h_reg       <= STEP_RST;
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= START_RST;
                pos_reg[i]   <= satv(s32w(START_RST));
            end
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DX;
            stage_reg   <= 2'd0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            method_reg  <= method_next;
            sigma_reg   <= sigma_next;
            rho_reg     <= rho_next;
            beta_reg    <= beta_next;
            h_reg       <= h_next;
            start_reg   <= start_next;
            pos_reg     <= pos_next;
            state_reg   <= state_next;
            op_reg      <= op_next;
            stage_reg   <= stage_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        ovf_reg   <= ovf_next;
        s_reg     <= s_next;
        d_reg     <= d_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        m_idx_reg <= m_idx_next;
        m_x_reg   <= m_x_next;
        m_y_reg   <= m_y_next;
        m_z_reg   <= m_z_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_step_index = m_idx_reg;
    assign m_out_x      = m_x_reg;
    assign m_out_y      = m_y_reg;
    assign m_out_z      = m_z_reg;
    assign m_overflow   = m_ovf_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start the sequencer");

    a_done_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mstat.done |-> (state_reg == ST_WAIT))
        else $error("product finished outside the wait state");

    a_op_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg <= OP_D6Z))
        else $error("operation counter ran past the last operation");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready))
            |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished step was not moved to the output register");
`endif

endmodule

`default_nettype wire

/* sv/lrk4_mul.sv */
`default_nettype none

module lrk4_mul
    import lrk4_pkg::*;
#(
    parameter int VALUE_BITS = LRK4_VALUE_BITS,
    parameter int FRAC_BITS  = LRK4_FRAC_BITS
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  lrk4_mcmd_t                                     cmd,
    input  logic signed [lrk4_mag_width(VALUE_BITS):0]     op_a,
    input  logic signed [lrk4_mag_width(VALUE_BITS):0]     op_b,
    output lrk4_mstat_t                                    stat,
    output logic signed [VALUE_BITS-1:0]                   res
);

    localparam int MW     = lrk4_mag_width(VALUE_BITS);
    localparam int PW     = 2 * MW;
    localparam int DG     = 16;
    localparam int NDIG   = (MW + DG - 1) / DG;
    localparam int UBW    = NDIG * DG;
    localparam int CW     = $clog2(NDIG + 1);
    localparam int DIV_SH = VALUE_BITS + 5;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_RND  = 2'd2;

    logic [1:0]            phase_reg, phase_next;
    logic [CW-1:0]         dig_reg, dig_next;
    logic [MW-1:0]         ua_reg, ua_next;
    logic [UBW-1:0]        ub_reg, ub_next;
    logic [PW-1:0]         acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [1:0]            sel_reg, sel_next;
    logic                  done_reg, done_next;
    logic                  sat_reg, sat_next;
    logic signed [VALUE_BITS-1:0] res_reg, res_next;

    logic signed [MW:0] mag_a, mag_b;
    logic [PW:0]        rnd, sum, q, qn, lim;
    logic               ovf;

    assign mag_a = op_a[MW] ? -op_a : op_a;
    assign mag_b = op_b[MW] ? -op_b : op_b;

    // rounding constant and scaling by product kind
    always_comb begin
        unique case (sel_reg)
            SH_FRAC: rnd = (PW + 1)'(1) << (FRAC_BITS - 1);
            SH_H:    rnd = (PW + 1)'(1) << 31;
            default: rnd = '0;
        endcase
        sum = {1'b0, acc_reg} + rnd;
        unique case (sel_reg)
            SH_FRAC: q = sum >> FRAC_BITS;
            SH_H:    q = sum >> 32;
            SH_DIV:  q = sum >> DIV_SH;
            default: q = sum;
        endcase
    end

    assign lim = ((PW + 1)'(1) << (VALUE_BITS - 1)) - (PW + 1)'(!neg_reg);
    assign ovf = q > lim;
    assign qn  = neg_reg ? -q : q;

    always_comb begin
        phase_next = phase_reg;
        dig_next   = dig_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sel_next   = sel_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        res_next   = res_reg;
        unique case (phase_reg)
            P_IDLE: begin
                if (cmd.go) begin
                    ua_next    = mag_a[MW-1:0];
                    ub_next    = UBW'(mag_b[MW-1:0]);
                    neg_next   = op_a[MW] ^ op_b[MW];
                    sel_next   = cmd.sel;
                    acc_next   = '0;
                    dig_next   = CW'(NDIG);
                    phase_next = P_MUL;
                end
            end
            P_MUL: begin
                // one 16-bit digit of b per cycle, most significant first
                acc_next = (acc_reg << DG) + (PW'(ua_reg) * PW'(ub_reg[UBW-1 -: DG]));
                ub_next  = ub_reg << DG;
                dig_next = dig_reg - CW'(1);
                if (dig_reg == CW'(1)) begin
                    phase_next = P_RND;
                end
            end
            P_RND: begin
                res_next   = ovf ? {neg_reg, {(VALUE_BITS - 1){!neg_reg}}}
                                 : qn[VALUE_BITS-1:0];
                sat_next   = ovf && (sel_reg != SH_DIV);
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        dig_reg <= dig_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        sel_reg <= sel_next;
        sat_reg <= sat_next;
        res_reg <= res_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
